/* rtl/mtg_pkg.sv */
// Package for the Morse tone generator: widths, element and register codes,
// the constant sine magnitude table and the Q1.15 output scaling.
// No dependencies.
package mtg_pkg;

    // Table and sample format
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SAMPLE_BITS      = 16;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
    localparam int MAG_W            = SAMPLE_BITS - 1;

    // Register and derived widths
    localparam int PHASE_W = 32;
    localparam int UNIT_W  = 16;
    localparam int RAMP_W  = 12;
    localparam int POS_W   = 19;
    localparam int PROD_W  = MAG_W + RAMP_W;
    localparam int SER_STEPS = (MAG_W > RAMP_W) ? MAG_W : RAMP_W;
    localparam int CNT_W   = $clog2(SER_STEPS);

    // Element codes
    localparam logic [2:0] ELEM_NONE = 3'd0;
    localparam logic [2:0] ELEM_DIT  = 3'd1;
    localparam logic [2:0] ELEM_DAH  = 3'd2;
    localparam logic [2:0] ELEM_LGAP = 3'd3;
    localparam logic [2:0] ELEM_WGAP = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [1:0] REG_UNIT       = 2'd1;
    localparam logic [1:0] REG_RAMP_UP    = 2'd2;
    localparam logic [1:0] REG_RAMP_DOWN  = 2'd3;

    // Fixed-point constants for the table build
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] AMP_MAX = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    // Output scaling shifts
    localparam int Q_SH_R = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
    localparam int Q_SH_L = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
    localparam logic [31:0] Q_HALF = (Q_SH_R > 0) ? (32'd1 << (Q_SH_R - 1)) : 32'd0;

    // Operands handed to the envelope scaler
    typedef struct packed {
        logic [MAG_W-1:0]  mag;
        logic [RAMP_W-1:0] num;
        logic [RAMP_W-1:0] den;
    } mtg_env_t;

    typedef logic [MAG_W-1:0] sine_tab_t [SINE_TABLE_DEPTH];

    // Sine of a quarter-wave angle, Q2.30 in and out, odd Taylor terms to x^13
    function automatic logic [63:0] sin_q30(input logic [63:0] theta);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        x2   = (theta * theta) >> 30;
        term = theta;
        pos  = theta;
        neg  = 64'd0;
        term = ((term * x2) >> 30) / 64'd6;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd20;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd42;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd72;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd110;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd156;
        pos  = pos + term;
        r = (pos > neg) ? pos - neg : 64'd0;
        return (r > ONE_Q30) ? ONE_Q30 : r;
    endfunction

    // Magnitude table, folded onto the quarter wave; sign comes from the index MSB
    function automatic sine_tab_t build_sine();
        sine_tab_t   tab;
        logic [63:0] f;
        logic [63:0] theta;
        logic [63:0] mag;
        int          i;
        for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
            f = 64'(i) << (32 - IDX_W);
            f = f & 64'h7FFF_FFFF;
            if (f > 64'h4000_0000) begin
                f = 64'h8000_0000 - f;
            end
            theta  = (f * (PI_Q30 << 1)) >> 32;
            mag    = (sin_q30(theta) * AMP_MAX + (64'd1 << 29)) >> 30;
            tab[i] = mag[MAG_W-1:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_MAG = build_sine();

    // Bring a magnitude from SAMPLE_BITS to Q1.15 and clamp
    function automatic logic [14:0] to_q15(input logic [MAG_W-1:0] mag);
        logic [31:0] v;
        v = ((32'(mag) + Q_HALF) >> Q_SH_R) << Q_SH_L;
        return (v > 32'd32767) ? 15'h7FFF : v[14:0];
    endfunction

endpackage

/* rtl/mtg_env_scale.sv */
// Envelope scaler: (mag * num + den/2) / den by a shift-add multiply then a
// restoring divide, one bit per cycle. Depends on mtg_pkg.
module mtg_env_scale
    import mtg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  mtg_env_t         req,
    output logic             done,
    output logic [MAG_W-1:0] quot
);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;

    logic [1:0]        state_reg,  state_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              done_reg,   done_next;
    logic [PROD_W-1:0] mcand_reg,  mcand_next;
    logic [RAMP_W-1:0] mult_reg,   mult_next;
    logic [PROD_W-1:0] prod_reg,   prod_next;
    logic [RAMP_W-1:0] den_reg,    den_next;
    logic [RAMP_W-1:0] rem_reg,    rem_next;
    logic [MAG_W-1:0]  quot_reg,   quot_next;

    logic [PROD_W-1:0] prod_sum;
    logic [RAMP_W:0]   trial;
    logic [RAMP_W:0]   trial_diff;
    logic              trial_ge;

    // One multiply step and one divide step
    always_comb begin
        prod_sum   = prod_reg + (mult_reg[0] ? mcand_reg : '0);
        trial      = {rem_reg, quot_reg[MAG_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        trial_ge   = trial >= {1'b0, den_reg};
    end

    // Sequence the multiply and divide passes
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        unique case (state_reg)
            U_IDLE: begin
                if (start) begin
                    mcand_next = PROD_W'(req.mag);
                    mult_next  = req.num;
                    prod_next  = PROD_W'(req.den >> 1);
                    den_next   = req.den;
                    cnt_next   = '0;
                    state_next = U_MUL;
                end
            end
            U_MUL: begin
                prod_next  = prod_sum;
                mcand_next = mcand_reg << 1;
                mult_next  = mult_reg >> 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RAMP_W - 1)) begin
                    // quotient fits MAG_W bits, so the top part starts below den
                    rem_next   = prod_sum[PROD_W-1:MAG_W];
                    quot_next  = prod_sum[MAG_W-1:0];
                    cnt_next   = '0;
                    state_next = U_DIV;
                end
            end
            U_DIV: begin
                rem_next  = trial_ge ? trial_diff[RAMP_W-1:0] : trial[RAMP_W-1:0];
                quot_next = {quot_reg[MAG_W-2:0], trial_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        prod_reg  <= prod_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/morse_tone_generator.sv */
// Morse keyed sine tone generator, top level: request and sample channels,
// configuration registers, element sequencing. Depends on mtg_pkg, mtg_env_scale.
//
// Usage:
//  - Each input word on s_ carries element_request in s_tdata[2:0] (0 none,
//    1 dit, 2 dah, 3 letter gap, 4 word gap). Every input word yields exactly
//    one output word: a signed Q1.15 sample in m_tdata, active in m_tuser and
//    the last-sample-of-element flag in m_tlast.
//  - A request starts an element only while no element runs; otherwise it is
//    ignored and simply clocks out the next sample of the running element.
//  - Each word is accepted, loaded, set up, scaled in the bit-serial
//    envelope scaler (shift-add multiply steps, then restoring divide
//    steps) and output; s_tready stays low until the sample of the taken
//    word has moved into the output register.
//  - The output register decouples the sides: s_tready returns while a
//    finished sample still waits; if the receiver stalls, the next sample is
//    held in the scaler until the output register frees.
//  - Reset (aresetn low, synchronous) returns to idle and loads the default
//    register values. Write configuration through cfg_we/cfg_index/cfg_data
//    only while idle.
module morse_tone_generator
    import mtg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] element_request, [7:3] zero
    // sample channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample
    output logic        m_tuser,   // [0] active
    output logic        m_tlast    // element_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]         state_reg,   state_next;
    logic [PHASE_W-1:0] step_reg,    step_next;
    logic [UNIT_W-1:0]  unit_reg,    unit_next;
    logic [RAMP_W-1:0]  rup_reg,     rup_next;
    logic [RAMP_W-1:0]  rdn_reg,     rdn_next;
    logic [2:0]         cur_reg,     cur_next;
    logic [POS_W-1:0]   pos_reg,     pos_next;
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic [POS_W-1:0]   dur_reg,     dur_next;
    logic [MAG_W-1:0]   mag_reg,     mag_next;
    logic               neg_reg,     neg_next;
    logic               tone_reg,    tone_next;
    logic               act_reg,     act_next;
    logic               last_reg,    last_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_sample_reg, out_sample_next;
    logic               out_active_reg, out_active_next;
    logic               out_last_reg,   out_last_next;

    logic [2:0]         req;
    logic               req_ok;
    logic               in_take;
    logic [POS_W-1:0]   unit_ext;
    logic [POS_W-1:0]   dur_calc;
    logic               cur_tone;
    logic [RAMP_W-1:0]  ru_eff;
    logic [RAMP_W-1:0]  rd_eff;
    logic               x_le_ru;
    logic               in_mid;
    logic               tone_last;
    logic               gap_last;
    logic [POS_W-1:0]   fall_len;
    logic               item_last;
    mtg_env_t           env_req;
    logic               env_start;
    logic               env_done;
    logic [MAG_W-1:0]   env_quot;
    logic [14:0]        q15;
    logic               out_free;

    assign req      = s_tdata[2:0];
    assign req_ok   = (req == ELEM_DIT) || (req == ELEM_DAH) ||
                      (req == ELEM_LGAP) || (req == ELEM_WGAP);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Element duration in samples; a zero unit acts as one
    always_comb begin
        unit_ext = POS_W'((unit_reg == '0) ? UNIT_W'(1) : unit_reg);
        unique case (cur_reg)
            ELEM_DIT:             dur_calc = unit_ext;
            ELEM_DAH, ELEM_LGAP:  dur_calc = (unit_ext << 1) + unit_ext;
            ELEM_WGAP:            dur_calc = (unit_ext << 3) - unit_ext;
            default:              dur_calc = unit_ext;
        endcase
        cur_tone = (cur_reg == ELEM_DIT) || (cur_reg == ELEM_DAH);
    end

    // Envelope branch and end-of-element tests
    always_comb begin
        ru_eff    = (rup_reg == '0) ? RAMP_W'(1) : rup_reg;
        rd_eff    = (rdn_reg == '0) ? RAMP_W'(1) : rdn_reg;
        x_le_ru   = pos_reg <= POS_W'(ru_eff);
        in_mid    = ({1'b0, pos_reg} + (POS_W + 1)'(rd_eff)) < {1'b0, dur_reg};
        tone_last = pos_reg >= dur_reg;
        gap_last  = ({1'b0, pos_reg} + (POS_W + 1)'(1)) >= {1'b0, dur_reg};
        fall_len  = (dur_reg > pos_reg) ? dur_reg - pos_reg : '0;
        item_last = act_reg && (tone_reg ? tone_last : gap_last);

        env_req.mag = mag_reg;
        env_req.num = '0;
        env_req.den = RAMP_W'(1);
        if (act_reg && tone_reg) begin
            priority if (x_le_ru) begin
                env_req.num = pos_reg[RAMP_W-1:0];
                env_req.den = ru_eff;
            end else if (in_mid) begin
                env_req.num = RAMP_W'(1);
                env_req.den = RAMP_W'(1);
            end else begin
                env_req.num = fall_len[RAMP_W-1:0];
                env_req.den = rd_eff;
            end
        end
        env_start = (state_reg == ST_PREP);
    end

    mtg_env_scale u_env (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (env_start),
        .req     (env_req),
        .done    (env_done),
        .quot    (env_quot)
    );

    assign q15 = to_q15(env_quot);

    // Sequencer, element state and output register
    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        unit_next       = unit_reg;
        rup_next        = rup_reg;
        rdn_next        = rdn_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        dur_next        = dur_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        tone_next       = tone_reg;
        act_next        = act_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_sample_next = out_sample_reg;
        out_active_next = out_active_reg;
        out_last_next   = out_last_reg;

        // register writes
        if (cfg_we) begin
            unique case (cfg_index)
                REG_PHASE_STEP: step_next = cfg_data;
                REG_UNIT:       unit_next = cfg_data[UNIT_W-1:0];
                REG_RAMP_UP:    rup_next  = cfg_data[RAMP_W-1:0];
                REG_RAMP_DOWN:  rdn_next  = cfg_data[RAMP_W-1:0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    // start an element only when none runs
                    if (cur_reg == ELEM_NONE && req_ok) begin
                        cur_next   = req;
                        pos_next   = '0;
                        phase_next = '0;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                act_next   = (cur_reg != ELEM_NONE);
                tone_next  = cur_tone;
                dur_next   = dur_calc;
                mag_next   = ((cur_reg != ELEM_NONE) && cur_tone) ?
                             SINE_MAG[phase_reg[PHASE_W-1 -: IDX_W]] : '0;
                neg_next   = phase_reg[PHASE_W-1];
                state_next = ST_PREP;
            end
            ST_PREP: begin
                last_next = item_last;
                if (act_reg) begin
                    if (item_last) begin
                        cur_next   = ELEM_NONE;
                        pos_next   = '0;
                        phase_next = '0;
                    end else begin
                        pos_next   = pos_reg + 1'b1;
                        phase_next = phase_reg + step_reg;
                    end
                end
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (env_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_sample_next = (neg_reg && q15 != '0) ?
                                      16'd0 - {1'b0, q15} : {1'b0, q15};
                    out_active_next = act_reg;
                    out_last_next   = last_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= 32'd77922071;
            unit_reg      <= 16'd11025;
            rup_reg       <= 12'd220;
            rdn_reg       <= 12'd220;
            cur_reg       <= ELEM_NONE;
            pos_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            unit_reg      <= unit_next;
            rup_reg       <= rup_next;
            rdn_reg       <= rdn_next;
            cur_reg       <= cur_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
        dur_reg        <= dur_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        tone_reg       <= tone_next;
        act_reg        <= act_next;
        last_reg       <= last_next;
        out_sample_reg <= out_sample_next;
        out_active_reg <= out_active_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_active_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while one is in flight");

    a_last_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("element end flagged on an idle sample");

    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        env_done |-> (state_reg == ST_WAIT))
        else $error("scaler finished outside the wait state");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_reg == ELEM_NONE) |-> (pos_reg == '0 && phase_reg == '0))
        else $error("position or phase left over while idle");
`endif

endmodule

/* dv/mtg_sample_checker.sv */
// Sample checker for the Morse tone generator: follows the register writes and
// the request words, predicts every sample word and compares it with the sample channel.
// Depends on mtg_pkg for the element and register codes.
module mtg_sample_checker
    import mtg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] element_request, [7:3] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] sample
    input  logic        m_tuser,   // [0] active
    input  logic        m_tlast,   // element_last
    output int          fail_count,
    output int          pending_words,
    output int          words_checked,
    output logic        keyer_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_LEN      = 256;
    localparam int          SAMPLE_W       = 16;
    localparam logic [63:0] PI_Q2_30       = 64'd3373259426;
    localparam logic [63:0] UNITY_Q2_30    = 64'd1 << 30;
    localparam logic [63:0] PEAK           = (64'd1 << (SAMPLE_W - 1)) - 64'd1;
    localparam logic [63:0] Q15_MAX        = 64'd32767;
    localparam logic [63:0] DAH_UNITS      = 64'd3;
    localparam logic [63:0] WORD_GAP_UNITS = 64'd7;

    // Register values after reset
    localparam logic [31:0] RST_STEP = 32'd77922071;
    localparam logic [15:0] RST_UNIT = 16'd11025;
    localparam logic [11:0] RST_RAMP = 12'd220;

    typedef struct packed {
        logic [15:0] sample;
        logic        active;
        logic        last;
    } sample_word_t;

    logic [31:0] wave_mag [TABLE_LEN];
    logic        wave_neg [TABLE_LEN];

    // Own copy of the registers and of the keyer state
    logic [31:0] step_reg;
    logic [15:0] unit_reg;
    logic [11:0] rise_reg;
    logic [11:0] fall_reg;
    logic [18:0] x_pos;
    logic [31:0] phase_acc;
    logic [2:0]  elem;

    sample_word_t expected_samples [$];
    int errors  = 0;
    int checked = 0;

    // Sine on [0, pi/2] in Q2.30, odd Taylor terms up to the 13th power, truncated
    function automatic logic [63:0] quarter_sine(input logic [63:0] ang);
        logic [63:0] sq;
        logic [63:0] term;
        logic [63:0] plus;
        logic [63:0] minus;
        logic [63:0] r;
        int          k;
        sq    = (ang * ang) >> 30;
        term  = ang;
        plus  = ang;
        minus = 64'd0;
        for (k = 1; k <= 6; k++) begin
            term = ((term * sq) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                minus = minus + term;
            end else begin
                plus = plus + term;
            end
        end
        r = (plus > minus) ? plus - minus : 64'd0;
        return (r > UNITY_Q2_30) ? UNITY_Q2_30 : r;
    endfunction

    // Build the magnitude and sign table, folded onto the quarter wave
    initial begin : fill_wave
        logic [63:0] f;
        logic [63:0] ang;
        logic [63:0] mag;
        logic        upper;
        for (int i = 0; i < TABLE_LEN; i++) begin
            f     = (64'(i) << 32) / TABLE_LEN;
            upper = f >= 64'h8000_0000;
            f     = f & 64'h7FFF_FFFF;
            if (f > 64'h4000_0000) begin
                f = 64'h8000_0000 - f;
            end
            ang         = (f * (PI_Q2_30 << 1)) >> 32;
            mag         = (quarter_sine(ang) * PEAK + (64'd1 << 29)) >> 30;
            wave_mag[i] = mag[31:0];
            wave_neg[i] = upper && (mag != 64'd0);
        end
    end

    // Advance the keyer by one request word and give the sample word it yields
    task automatic predict_sample(input logic [2:0] req, output sample_word_t w);
        logic [63:0] unit;
        logic [63:0] dur;
        logic [63:0] x;
        logic [63:0] ru;
        logic [63:0] rd;
        logic [63:0] idx;
        logic [63:0] m;
        logic [63:0] mag;
        logic        fin;
        w = '0;
        // an idle keyer takes a request only for a known element
        if (elem == ELEM_NONE) begin
            if (req < ELEM_DIT || req > ELEM_WGAP) begin
                return;
            end
            elem      = req;
            x_pos     = '0;
            phase_acc = '0;
        end
        unit = (unit_reg != 16'd0) ? 64'(unit_reg) : 64'd1;
        case (elem)
            ELEM_DIT:  dur = unit;
            ELEM_WGAP: dur = unit * WORD_GAP_UNITS;
            default:   dur = unit * DAH_UNITS;
        endcase
        x = 64'(x_pos);
        if (elem == ELEM_DIT || elem == ELEM_DAH) begin
            ru  = (rise_reg != 12'd0) ? 64'(rise_reg) : 64'd1;
            rd  = (fall_reg != 12'd0) ? 64'(fall_reg) : 64'd1;
            idx = (64'(phase_acc) * TABLE_LEN) >> 32;
            m   = 64'(wave_mag[idx]);
            // rising ramp, flat top, falling ramp, checked in that order
            if (x <= ru) begin
                mag = (m * x + ru / 2) / ru;
            end else if (x + rd < dur) begin
                mag = m;
            end else begin
                mag = (m * ((dur > x) ? dur - x : 64'd0) + rd / 2) / rd;
            end
            // sample width already matches Q1.15: clamp only
            if (mag > Q15_MAX) begin
                mag = Q15_MAX;
            end
            w.sample = wave_neg[idx] ? -mag[15:0] : mag[15:0];
            fin      = x >= dur;
        end else begin
            fin = x + 64'd1 >= dur;
        end
        w.active = 1'b1;
        w.last   = fin;
        if (fin) begin
            elem      = ELEM_NONE;
            x_pos     = '0;
            phase_acc = '0;
        end else begin
            x_pos     = x_pos + 19'd1;
            phase_acc = phase_acc + step_reg;
        end
    endtask

    task automatic flag(input string what, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge aclk) begin : track
        sample_word_t want;
        sample_word_t got;
        if (!aresetn) begin
            step_reg  = RST_STEP;
            unit_reg  = RST_UNIT;
            rise_reg  = RST_RAMP;
            fall_reg  = RST_RAMP;
            elem      = ELEM_NONE;
            x_pos     = '0;
            phase_acc = '0;
            expected_samples.delete();
        end else begin
            // predict the word that each accepted request produces
            if (s_tvalid && s_tready) begin
                predict_sample(s_tdata[2:0], want);
                expected_samples.push_back(want);
            end
            // follow register writes; they act from the next request on
            if (cfg_we) begin
                case (cfg_index)
                    REG_PHASE_STEP: step_reg = cfg_data;
                    REG_UNIT:       unit_reg = cfg_data[15:0];
                    REG_RAMP_UP:    rise_reg = cfg_data[11:0];
                    REG_RAMP_DOWN:  fall_reg = cfg_data[11:0];
                    default:        ;
                endcase
            end
            // compare each delivered word with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.sample = m_tdata;
                got.active = m_tuser;
                got.last   = m_tlast;
                checked++;
                if (expected_samples.size() == 0) begin
                    errors++;
                    $display("%0t: sample word mismatch, expected no word, got %0d",
                             $time, $signed(got.sample));
                end else begin
                    want = expected_samples.pop_front();
                    if (got.sample !== want.sample) begin
                        flag("sample", $signed(want.sample), $signed(got.sample));
                    end
                    if (got.active !== want.active) begin
                        flag("active", want.active, got.active);
                    end
                    if (got.last !== want.last) begin
                        flag("element_last", want.last, got.last);
                    end
                end
            end
        end
        fail_count    <= errors;
        pending_words <= expected_samples.size();
        words_checked <= checked;
        keyer_busy    <= (elem != ELEM_NONE);
    end

endmodule

/* dv/tb_morse_tone_generator.sv */
// Testbench top for the Morse tone generator: drives requests, register writes and
// receiver stalls, and gives the verdict from the sample checker's failure count.
// Depends on mtg_pkg, morse_tone_generator and mtg_sample_checker.
module tb_morse_tone_generator
    import mtg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int PHASE_WORDS   = 64;
    localparam int RANDOM_PHASES = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int HEAVY_IDLE    = 82;
    localparam int LIGHT_IDLE    = 18;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [2:0] element_request, [7:3] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] sample
    logic        m_tuser;   // [0] active
    logic        m_tlast;   // element_last

    int   fail_count;
    int   pending_words;
    int   words_checked;
    logic keyer_busy;

    int gap_pct       = 0;
    int stall_pct     = 0;
    int requests_sent = 0;
    int settings_used = 1;

    morse_tone_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    mtg_sample_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .words_checked (words_checked),
        .keyer_busy    (keyer_busy)
    );

    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    // Watchdog: if the stimulus has not finished by this delay, report a scoreboard
    // mismatch and stop.
    initial begin : watchdog
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: drop ready on each cycle with the chosen probability
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one request word, idling on each cycle ahead of it with the chosen probability
    task automatic send_request(input logic [2:0] req);
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    // Keep clocking words until the running element has ended
    task automatic finish_element(input bit busy_noise);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (keyer_busy) begin
            send_request(busy_noise ? 3'($urandom_range(0, 7)) : ELEM_NONE);
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic settle();
        while (pending_words != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    // Load all four registers on consecutive cycles; the keyer must be idle
    task automatic load_keyer_regs(input logic [31:0] step, input logic [15:0] unit,
                                   input logic [11:0] rise, input logic [11:0] fall);
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_UNIT, 32'(unit));
        write_reg(REG_RAMP_UP, 32'(rise));
        write_reg(REG_RAMP_DOWN, 32'(fall));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // One of each element, each run to its end with stray requests while busy
    task automatic play_each_element();
        send_request(ELEM_DIT);
        finish_element(1'b1);
        send_request(ELEM_DAH);
        finish_element(1'b1);
        send_request(ELEM_LGAP);
        finish_element(1'b1);
        send_request(ELEM_WGAP);
        finish_element(1'b1);
        settle();
    endtask

    // Requests that start nothing: none and the unused codes above the word gap
    task automatic send_idle_codes();
        send_request(ELEM_NONE);
        for (int r = ELEM_WGAP + 1; r < 8; r++) begin
            send_request(3'(r));
        end
        finish_element(1'b0);
        settle();
    endtask

    // Mostly element requests, the rest none or unused codes
    function automatic logic [2:0] pick_request();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return 3'($urandom_range(ELEM_DIT, ELEM_WGAP));
        end else if (roll < 85) begin
            return ELEM_NONE;
        end
        return 3'($urandom_range(ELEM_WGAP + 1, 7));
    endfunction

    function automatic logic [11:0] pick_ramp();
        if ($urandom_range(0, 9) == 0) begin
            return 12'hFFF;
        end
        return 12'($urandom_range(1, 40));
    endfunction

    initial begin : stimulus
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_PHASE_STEP;
        cfg_data  = 32'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: idle codes only, a default-length element is far too long
        send_idle_codes();
        // Reset step and ramps with a short unit: a dit inside its rising ramp
        write_reg(REG_UNIT, 32'd8);
        cfg_we <= 1'b0;
        settings_used++;
        send_request(ELEM_DIT);
        finish_element(1'b0);
        settle();

        // Half-turn phase step, shortest ramps
        load_keyer_regs(32'h8000_0000, 16'd4, 12'd1, 12'd1);
        play_each_element();
        // Zero phase step, rising ramp far longer than the tone
        load_keyer_regs(32'd0, 16'd2, 12'hFFF, 12'd1);
        play_each_element();
        // Zero unit and ramps act as one
        load_keyer_regs(32'h1357_9BDF, 16'd0, 12'd0, 12'd0);
        play_each_element();
        // Both ramps at their longest on a short tone
        load_keyer_regs($urandom, 16'd3, 12'hFFF, 12'hFFF);
        play_each_element();
        // Long dah with a flat top between short ramps
        load_keyer_regs($urandom, 16'd40, 12'd7, 12'd9);
        send_request(ELEM_DAH);
        finish_element(1'b0);
        settle();
        // Largest values; only non-starting requests, a full element would take too long
        load_keyer_regs(32'hFFFF_FFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
        send_idle_codes();

        // Random phases, idling mode cycling through none, sender, receiver, both
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0:       begin gap_pct = 0;          stall_pct = 0;          end
                1:       begin gap_pct = HEAVY_IDLE; stall_pct = 0;          end
                2:       begin gap_pct = 0;          stall_pct = HEAVY_IDLE; end
                default: begin gap_pct = LIGHT_IDLE; stall_pct = LIGHT_IDLE; end
            endcase
            load_keyer_regs($urandom, 16'($urandom_range(1, 24)), pick_ramp(), pick_ramp());
            repeat (PHASE_WORDS) send_request(pick_request());
            finish_element(1'b1);
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Drove %0d request words over %0d register settings; %0d sample words compared.",
                 requests_sent, settings_used, words_checked);
        $display("Idling covered free running, sender gaps, receiver stalls and both together.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mtg_pkg.sv
rtl/mtg_env_scale.sv
rtl/morse_tone_generator.sv
dv/mtg_sample_checker.sv
dv/tb_morse_tone_generator.sv
